/* design/doeq_pkg.sv */
// Package for the deadline-ordered event queue.
// Holds action codes, sequencer states, cell operations and fixed field widths.
// No dependencies.
package doeq_pkg;

   localparam int TAG_BITS   = 16;
   localparam int DELAY_BITS = 32;
   localparam int COUNT_BITS = 5;
   localparam int MULT_BITS  = 10;
   localparam int PROD_BITS  = DELAY_BITS + MULT_BITS;

   localparam logic [MULT_BITS-1:0] MS_TO_US = 10'd1000;

   localparam logic [1:0] ACT_ABS  = 2'd0;
   localparam logic [1:0] ACT_REL  = 2'd1;
   localparam logic [1:0] ACT_POLL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_APPLY
   } seq_state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [TAG_BITS-1:0] new_tag;
   } cell_ctl_type;

endpackage

/* design/doeq_cell.sv */
// One slot of the sorted event chain: a deadline and a job tag.
// Depends on doeq_pkg for the control struct and cell operations.
module doeq_cell #(
   parameter int TIME_BITS = 48
) (
   input  logic                          clock,
   input  doeq_pkg::cell_ctl_type        ctl,
   input  logic [TIME_BITS-1:0]          new_deadline,
   input  logic                          slot_valid,
   input  logic                          slot_tail,
   input  logic                          left_gt,
   input  logic [TIME_BITS-1:0]          left_deadline,
   input  logic [doeq_pkg::TAG_BITS-1:0] left_tag,
   input  logic [TIME_BITS-1:0]          right_deadline,
   input  logic [doeq_pkg::TAG_BITS-1:0] right_tag,
   output logic                          gt,
   output logic [TIME_BITS-1:0]          deadline,
   output logic [doeq_pkg::TAG_BITS-1:0] tag
);
   import doeq_pkg::*;

   logic [TIME_BITS-1:0] deadline_ff, deadline_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;

   // queued entries later than the new deadline move one slot toward the tail
   assign gt = slot_valid && (deadline_ff > new_deadline);

   always_comb begin
      deadline_in = deadline_ff;
      tag_in      = tag_ff;
      unique case (ctl.op)
         OP_INSERT: begin
            if (gt || slot_tail) begin
               if (left_gt) begin
                  deadline_in = left_deadline;
                  tag_in      = left_tag;
               end else begin
                  deadline_in = new_deadline;
                  tag_in      = ctl.new_tag;
               end
            end
         end
         OP_POP: begin
            deadline_in = right_deadline;
            tag_in      = right_tag;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      tag_ff      <= tag_in;
   end

   assign deadline = deadline_ff;
   assign tag      = tag_ff;

endmodule

/* design/deadline_ordered_event_queue.sv */
// Top level of the deadline-ordered event queue: sequencer, count and result register.
// Depends on doeq_pkg and doeq_cell.
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_ready  | action, job_tag, deadline, delay_ms, now
//  rsp_    | out       | rsp_valid/rsp_ready  | fired, fired_tag, entry_count, dropped
//
// One transaction at a time: absolute adds and polls go from accept straight to the
// apply state; relative adds first pass a registered 32x10 multiply and a saturating add.
// The cell chain updates all slots at once; that update waits while an earlier
// result is not yet taken. Synchronous reset empties the queue (count to zero);
// slot contents are not cleared.
module deadline_ordered_event_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 48
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic [doeq_pkg::TAG_BITS-1:0]   req_job_tag,
   input  logic [TIME_BITS-1:0]            req_deadline,
   input  logic [doeq_pkg::DELAY_BITS-1:0] req_delay_ms,
   input  logic [TIME_BITS-1:0]            req_now,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_fired,
   output logic [doeq_pkg::TAG_BITS-1:0]   rsp_fired_tag,
   output logic [doeq_pkg::COUNT_BITS-1:0] rsp_entry_count,
   output logic                            rsp_dropped
);
   import doeq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int EXT_W = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;
   localparam int SUM_W = ((TIME_BITS > PROD_BITS) ? TIME_BITS : PROD_BITS) + 1;

   seq_state_type state_ff, state_in;

   logic [1:0]            action_ff, action_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [TIME_BITS-1:0]  when_ff, when_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [DELAY_BITS-1:0] delay_ff, delay_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  fired_ff, fired_in;
   logic [TAG_BITS-1:0]   fired_tag_ff, fired_tag_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                  dropped_ff, dropped_in;

   logic [SUM_W-1:0]      sum;
   logic [EXT_W-1:0]      count_ext;
   cell_ctl_type          ctl;

   logic [TIME_BITS-1:0]  cell_deadline [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]   cell_tag      [QUEUE_DEPTH];
   logic                  cell_gt       [QUEUE_DEPTH];

   assign sum = SUM_W'(now_ff) + SUM_W'(prod_ff);

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      tag_in       = tag_ff;
      when_in      = when_ff;
      now_in       = now_ff;
      delay_in     = delay_ff;
      prod_in      = prod_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      fired_in     = fired_ff;
      fired_tag_in = fired_tag_ff;
      rsp_count_in = rsp_count_ff;
      dropped_in   = dropped_ff;
      ctl.op       = OP_HOLD;
      ctl.new_tag  = tag_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in = req_action;
               tag_in    = req_job_tag;
               when_in   = req_deadline;
               now_in    = req_now;
               delay_in  = req_delay_ms;
               state_in  = (req_action == ACT_REL) ? ST_MUL : ST_APPLY;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(delay_ff) * PROD_BITS'(MS_TO_US);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // saturate to the largest time value on overflow
            if (sum[SUM_W-1:TIME_BITS] != '0) begin
               when_in = '1;
            end else begin
               when_in = sum[TIME_BITS-1:0];
            end
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               fired_in     = 1'b0;
               fired_tag_in = '0;
               dropped_in   = 1'b0;
               case (action_ff) inside
                  ACT_ABS, ACT_REL: begin
                     if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                        ctl.op   = OP_INSERT;
                        count_in = count_ff + 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  ACT_POLL: begin
                     if (count_ff != '0 && now_ff > cell_deadline[0]) begin
                        ctl.op       = OP_POP;
                        fired_in     = 1'b1;
                        fired_tag_in = cell_tag[0];
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 left_gt;
      logic [TIME_BITS-1:0] left_deadline, right_deadline;
      logic [TAG_BITS-1:0]  left_tag, right_tag;

      if (i == 0) begin : g_head
         assign left_gt       = 1'b0;
         assign left_deadline = when_ff;
         assign left_tag      = tag_ff;
      end else begin : g_link_left
         assign left_gt       = cell_gt[i-1];
         assign left_deadline = cell_deadline[i-1];
         assign left_tag      = cell_tag[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_deadline = cell_deadline[i];
         assign right_tag      = cell_tag[i];
      end else begin : g_link_right
         assign right_deadline = cell_deadline[i+1];
         assign right_tag      = cell_tag[i+1];
      end

      doeq_cell #(
         .TIME_BITS(TIME_BITS)
      ) u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .new_deadline  (when_ff),
         .slot_valid    (CNT_W'(i) < count_ff),
         .slot_tail     (CNT_W'(i) == count_ff),
         .left_gt       (left_gt),
         .left_deadline (left_deadline),
         .left_tag      (left_tag),
         .right_deadline(right_deadline),
         .right_tag     (right_tag),
         .gt            (cell_gt[i]),
         .deadline      (cell_deadline[i]),
         .tag           (cell_tag[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      tag_ff       <= tag_in;
      when_ff      <= when_in;
      now_ff       <= now_in;
      delay_ff     <= delay_in;
      prod_ff      <= prod_in;
      fired_ff     <= fired_in;
      fired_tag_ff <= fired_tag_in;
      rsp_count_ff <= rsp_count_in;
      dropped_ff   <= dropped_in;
   end

   assign count_ext       = EXT_W'(rsp_count_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired       = fired_ff;
   assign rsp_fired_tag   = fired_tag_ff;
   assign rsp_entry_count = count_ext[COUNT_BITS-1:0];
   assign rsp_dropped     = dropped_ff;

endmodule

/* design/doeq_checker.sv */
// Port-level checks for the deadline-ordered event queue, bound to the top level.
// Depends on doeq_pkg for field widths.
module doeq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_fired,
   input logic [doeq_pkg::TAG_BITS-1:0]   rsp_fired_tag,
   input logic [doeq_pkg::COUNT_BITS-1:0] rsp_entry_count,
   input logic                            rsp_dropped
);
   import doeq_pkg::*;

   // a result that fired nothing carries a zero tag
   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_fired_tag == '0)
      else $error("fired_tag nonzero without fired");

   a_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_fired && rsp_dropped))
      else $error("fired and dropped on one result");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired) && $stable(rsp_fired_tag)
         && $stable(rsp_entry_count) && $stable(rsp_dropped))
      else $error("stalled result changed");

endmodule

bind deadline_ordered_event_queue doeq_checker u_doeq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_fired      (rsp_fired),
   .rsp_fired_tag  (rsp_fired_tag),
   .rsp_entry_count(rsp_entry_count),
   .rsp_dropped    (rsp_dropped)
);
